/* hdl/learn_digest_dedup_batcher_core_defines.svh */
// Assertion macros used by the learn digest batcher back end.
`ifndef LEARN_DIGEST_DEDUP_BATCHER_CORE_DEFINES_SVH
`define LEARN_DIGEST_DEDUP_BATCHER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset
`define LDB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never hold
`define LDB_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LDB_ASSERT(lbl, prop, msg)
`define LDB_NEVER(lbl, cond, msg)
`endif
`endif

/* hdl/ldb_pkg.sv */
// Types and codes shared by the learn digest batcher modules.
package ldb_pkg;

    localparam int TAG_W  = 16;
    localparam int SLOT_W = 4;
    localparam int KEY_W  = 64;

    // Request codes on req_type
    localparam logic [2:0] REQ_LEARN    = 3'd0;
    localparam logic [2:0] REQ_TICK     = 3'd1;
    localparam logic [2:0] REQ_ACK_SLOT = 3'd2;
    localparam logic [2:0] REQ_ACK_BUF  = 3'd3;
    localparam logic [2:0] REQ_CLEAR    = 3'd4;

    // Configuration register indexes
    localparam logic CFG_BATCH_LIMIT = 1'b0;
    localparam logic CFG_TIMEOUT     = 1'b1;

    // Result kinds
    localparam logic KIND_FLUSH = 1'b0;
    localparam logic KIND_DROP  = 1'b1;

    typedef enum logic [2:0] {
        OP_LEARN,
        OP_TICK,
        OP_ACK_SLOT,
        OP_ACK_BUF,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [KEY_W-1:0]  key;
        logic [TAG_W-1:0]  tag;
        logic [SLOT_W-1:0] slot;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FLUSH
    } state_t;

endpackage

/* hdl/ldb_ram.sv */
// Generic single write port RAM with registered read.
module ldb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/ldb_front.sv */
// Front end: takes items, decodes the request and queues commands.
module ldb_front
    import ldb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        req_type,
    input  logic [KEY_W-1:0]  sample_key,
    input  logic [TAG_W-1:0]  buffer_tag,
    input  logic [SLOT_W-1:0] slot_index,
    output logic              cmd_valid,
    output cmd_t              cmd_head,
    input  logic              cmd_pop
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       known;
    op_t        op_dec;
    logic       push;

    // Request decoder; unknown codes are swallowed here
    always_comb
    begin
        known  = 1'b1;
        op_dec = OP_TICK;
        unique case (req_type)
            REQ_LEARN:    op_dec = OP_LEARN;
            REQ_TICK:     op_dec = OP_TICK;
            REQ_ACK_SLOT: op_dec = OP_ACK_SLOT;
            REQ_ACK_BUF:  op_dec = OP_ACK_BUF;
            REQ_CLEAR:    op_dec = OP_CLEAR;
            default:      known  = 1'b0;
        endcase
    end

    assign busy      = (cnt_reg == 2'd2);
    assign push      = start && !busy && known;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_head  = q_reg[rd_ptr_reg];

    // Queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = (cmd_pop && cmd_valid) ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(cmd_pop && cmd_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{op: op_dec, key: sample_key, tag: buffer_tag,
                                   slot: slot_index};
        end
    end

endmodule

/* hdl/ldb_back.sv */
// Back end: filter scan, batch store, timer and flush sequencer.
`include "learn_digest_dedup_batcher_core_defines.svh"
module ldb_back
    import ldb_pkg::*;
#(
    parameter int FILTER_DEPTH = 64,
    parameter int MAX_BATCH    = 16,
    parameter int KEY_BITS     = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  cmd_t              cmd_head,
    output logic              cmd_pop,
    input  logic [4:0]        batch_limit,
    input  logic [15:0]       timeout_ticks,
    output logic              result_strobe,
    output logic              result_kind,
    output logic [TAG_W-1:0]  batch_tag,
    output logic [4:0]        batch_size,
    output logic [SLOT_W-1:0] sample_slot,
    output logic [KEY_W-1:0]  learned_key,
    output logic              last_of_batch
);

    localparam int FAW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int FCW = $clog2(FILTER_DEPTH + 1);
    localparam int BAW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int BCW = $clog2(MAX_BATCH + 1);
    localparam int FW  = KEY_BITS + TAG_W + SLOT_W;

    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg;
    logic [KEY_BITS-1:0]     key_w;
    logic [BCW-1:0]          cnt_reg, cnt_next;
    logic [TAG_W-1:0]        tag_reg, tag_next;
    logic [15:0]             elapsed_reg, elapsed_next;
    logic                    run_reg, run_next;
    logic [FILTER_DEPTH-1:0] valid_reg, valid_next;
    logic [FCW-1:0]          idx_reg, idx_next;
    logic [BCW-1:0]          fl_idx_reg, fl_idx_next;
    logic                    pend_reg, pend_next;
    logic [FAW-1:0]          pend_idx_reg, pend_idx_next;
    logic [BCW-1:0]          pend_slot_reg, pend_slot_next;
    logic                    dup_reg, dup_next;
    logic                    free_reg, free_next;
    logic [FAW-1:0]          free_idx_reg, free_idx_next;

    logic                    res_strobe_reg, res_strobe_next;
    logic                    res_kind_reg, res_kind_next;
    logic [TAG_W-1:0]        res_tag_reg, res_tag_next;
    logic [4:0]              res_size_reg, res_size_next;
    logic [SLOT_W-1:0]       res_slot_reg, res_slot_next;
    logic [KEY_BITS-1:0]     res_key_reg, res_key_next;
    logic                    res_last_reg, res_last_next;

    logic                    scan_issue, flush_issue;
    logic                    f_we, b_we;
    logic [FW-1:0]           f_q;
    logic [KEY_BITS-1:0]     b_q;
    logic [KEY_BITS-1:0]     ent_key;
    logic [TAG_W-1:0]        ent_owner;
    logic [SLOT_W-1:0]       ent_slot;
    logic [6:0]              lim, cnt7, cnt_inc7;
    logic [15:0]             elapsed_inc;
    logic                    tick_flush, learn_ok, learn_flush, take;

    assign key_w     = cmd_reg.key[KEY_BITS-1:0];
    assign ent_key   = f_q[FW-1 -: KEY_BITS];
    assign ent_owner = f_q[SLOT_W +: TAG_W];
    assign ent_slot  = f_q[SLOT_W-1:0];

    // Effective batch limit, clamped to 1..MAX_BATCH
    always_comb
    begin
        if (batch_limit == 5'd0)
            lim = 7'd1;
        else if (7'(batch_limit) > 7'(MAX_BATCH))
            lim = 7'(MAX_BATCH);
        else
            lim = 7'(batch_limit);
    end

    assign cnt7        = 7'(cnt_reg);
    assign cnt_inc7    = cnt7 + 7'd1;
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign tick_flush  = (cnt_reg != '0) && ((cnt7 >= lim) ||
                         (run_reg && timeout_ticks != 16'd0 && elapsed_inc >= timeout_ticks));
    assign learn_ok    = !dup_reg && free_reg && (cnt7 < 7'(MAX_BATCH));
    assign learn_flush = cnt_inc7 >= lim;
    assign take        = cmd_pop;
    assign scan_issue  = (state_reg == ST_SCAN) && (idx_reg < FCW'(FILTER_DEPTH));
    assign flush_issue = (state_reg == ST_FLUSH) && (fl_idx_reg < cnt_reg);
    assign f_we        = (state_reg == ST_DECIDE) && learn_ok;
    assign b_we        = f_we;
    assign cmd_pop     = (state_reg == ST_IDLE) && cmd_valid;

    // Filter entries: key, owner tag and slot
    ldb_ram #(.WIDTH(FW), .DEPTH(FILTER_DEPTH)) u_filter (
        .clk   (clk),
        .we    (f_we),
        .waddr (free_idx_reg),
        .wdata ({key_w, tag_reg, SLOT_W'(cnt_reg)}),
        .re    (scan_issue),
        .raddr (idx_reg[FAW-1:0]),
        .rdata (f_q)
    );

    // Keys of the current batch
    ldb_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_BATCH)) u_batch (
        .clk   (clk),
        .we    (b_we),
        .waddr (cnt_reg[BAW-1:0]),
        .wdata (key_w),
        .re    (flush_issue),
        .raddr (fl_idx_reg[BAW-1:0]),
        .rdata (b_q)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd_head.op) inside
                        OP_LEARN, OP_ACK_SLOT, OP_ACK_BUF: state_next = ST_SCAN;
                        OP_TICK:  state_next = tick_flush ? ST_FLUSH : ST_IDLE;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (!scan_issue && !pend_reg)
                    state_next = (cmd_reg.op == OP_LEARN) ? ST_DECIDE : ST_IDLE;
            end
            ST_DECIDE:
                state_next = (learn_ok && learn_flush) ? ST_FLUSH : ST_IDLE;
            ST_FLUSH:
            begin
                if (!flush_issue && !pend_reg)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and result registers
    always_comb
    begin
        cnt_next        = cnt_reg;
        tag_next        = tag_reg;
        elapsed_next    = elapsed_reg;
        run_next        = run_reg;
        valid_next      = valid_reg;
        idx_next        = idx_reg;
        fl_idx_next     = fl_idx_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        pend_slot_next  = pend_slot_reg;
        dup_next        = dup_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        res_strobe_next = 1'b0;
        res_kind_next   = res_kind_reg;
        res_tag_next    = res_tag_reg;
        res_size_next   = res_size_reg;
        res_slot_next   = res_slot_reg;
        res_key_next    = res_key_reg;
        res_last_next   = res_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next    = '0;
                fl_idx_next = '0;
                dup_next    = 1'b0;
                free_next   = 1'b0;
                if (cmd_valid && cmd_head.op == OP_CLEAR)
                begin
                    valid_next   = '0;
                    cnt_next     = '0;
                    tag_next     = '0;
                    elapsed_next = '0;
                    run_next     = 1'b0;
                end
                else if (cmd_valid && cmd_head.op == OP_TICK && cnt_reg != '0 &&
                         cnt7 < lim && run_reg)
                begin
                    elapsed_next = elapsed_inc;
                end
            end
            ST_SCAN:
            begin
                // one entry read per cycle, compared in the cycle after its read
                if (scan_issue)
                begin
                    idx_next      = idx_reg + FCW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[FAW-1:0];
                end
                if (pend_reg)
                begin
                    if (cmd_reg.op == OP_LEARN)
                    begin
                        if (valid_reg[pend_idx_reg] && ent_key == key_w)
                            dup_next = 1'b1;
                        if (!valid_reg[pend_idx_reg] && !free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = pend_idx_reg;
                        end
                    end
                    else if (valid_reg[pend_idx_reg] && ent_owner == cmd_reg.tag &&
                             (cmd_reg.op == OP_ACK_BUF || ent_slot == cmd_reg.slot))
                    begin
                        valid_next[pend_idx_reg] = 1'b0;
                    end
                end
            end
            ST_DECIDE:
            begin
                if (!dup_reg)
                begin
                    if (!learn_ok)
                    begin
                        // filter or batch full: report the dropped key
                        res_strobe_next = 1'b1;
                        res_kind_next   = KIND_DROP;
                        res_tag_next    = tag_reg;
                        res_size_next   = 5'd0;
                        res_slot_next   = '0;
                        res_key_next    = key_w;
                        res_last_next   = 1'b1;
                    end
                    else
                    begin
                        valid_next[free_idx_reg] = 1'b1;
                        cnt_next = cnt_reg + BCW'(1);
                        if (!learn_flush && cnt_reg == '0)
                        begin
                            elapsed_next = '0;
                            run_next     = 1'b1;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (flush_issue)
                begin
                    fl_idx_next    = fl_idx_reg + BCW'(1);
                    pend_next      = 1'b1;
                    pend_slot_next = fl_idx_reg;
                end
                if (pend_reg)
                begin
                    res_strobe_next = 1'b1;
                    res_kind_next   = KIND_FLUSH;
                    res_tag_next    = tag_reg;
                    res_size_next   = 5'(cnt_reg);
                    res_slot_next   = SLOT_W'(pend_slot_reg);
                    res_key_next    = b_q;
                    res_last_next   = (pend_slot_reg + BCW'(1) == cnt_reg);
                end
                if (!flush_issue && !pend_reg)
                begin
                    cnt_next     = '0;
                    tag_next     = tag_reg + TAG_W'(1);
                    elapsed_next = '0;
                    run_next     = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            tag_reg        <= '0;
            elapsed_reg    <= '0;
            run_reg        <= 1'b0;
            valid_reg      <= '0;
            idx_reg        <= '0;
            fl_idx_reg     <= '0;
            pend_reg       <= 1'b0;
            dup_reg        <= 1'b0;
            free_reg       <= 1'b0;
            res_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            tag_reg        <= tag_next;
            elapsed_reg    <= elapsed_next;
            run_reg        <= run_next;
            valid_reg      <= valid_next;
            idx_reg        <= idx_next;
            fl_idx_reg     <= fl_idx_next;
            pend_reg       <= pend_next;
            dup_reg        <= dup_next;
            free_reg       <= free_next;
            res_strobe_reg <= res_strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
            cmd_reg <= cmd_head;
        pend_idx_reg  <= pend_idx_next;
        pend_slot_reg <= pend_slot_next;
        free_idx_reg  <= free_idx_next;
        res_kind_reg  <= res_kind_next;
        res_tag_reg   <= res_tag_next;
        res_size_reg  <= res_size_next;
        res_slot_reg  <= res_slot_next;
        res_key_reg   <= res_key_next;
        res_last_reg  <= res_last_next;
    end

    assign result_strobe = res_strobe_reg;
    assign result_kind   = res_kind_reg;
    assign batch_tag     = res_tag_reg;
    assign batch_size    = res_size_reg;
    assign sample_slot   = res_slot_reg;
    assign learned_key   = KEY_W'(res_key_reg);
    assign last_of_batch = res_last_reg;

    `LDB_NEVER(a_cnt_bound, cnt7 > 7'(MAX_BATCH), "batch count above capacity")
    `LDB_ASSERT(a_strobe_src, result_strobe |-> ($past(state_reg) == ST_DECIDE ||
        $past(state_reg) == ST_FLUSH), "result outside decide or flush")
    `LDB_ASSERT(a_tag_adv, (state_reg == ST_FLUSH && state_next == ST_IDLE) |=>
        (tag_reg == $past(tag_reg) + TAG_W'(1)), "buffer id did not advance")

endmodule

/* hdl/learn_digest_dedup_batcher_core.sv */
// Top level of the learn digest deduplicating batcher.
//
//  channel   signals                                         handshake
//  input     req_type sample_key buffer_tag slot_index       start & !busy
//  result    result_kind batch_tag batch_size sample_slot    result_strobe, one cycle
//            learned_key last_of_batch
//  config    cfg_index cfg_data                              cfg_we
//
// An ack or a learn scans every filter entry in the back end through its RAM read port,
// one entry per cycle, and a learn then passes the decide state. A flush sends one
// result per cycle from the batch RAM. Tick and clear are handled in the idle state.
// A two-entry command queue decouples the input from the back end; busy is high while
// it is full. Results cannot be held off. Reset clears all control state and the filter
// valid bits at once.
module learn_digest_dedup_batcher_core
    import ldb_pkg::*;
#(
    parameter int FILTER_DEPTH = 64,
    parameter int MAX_BATCH    = 16,
    parameter int KEY_BITS     = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        req_type,
    input  logic [KEY_W-1:0]  sample_key,
    input  logic [TAG_W-1:0]  buffer_tag,
    input  logic [SLOT_W-1:0] slot_index,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data,
    output logic              result_strobe,
    output logic              result_kind,
    output logic [TAG_W-1:0]  batch_tag,
    output logic [4:0]        batch_size,
    output logic [SLOT_W-1:0] sample_slot,
    output logic [KEY_W-1:0]  learned_key,
    output logic              last_of_batch
);

    logic [4:0]  batch_limit_reg;
    logic [15:0] timeout_reg;
    logic        cmd_valid;
    logic        cmd_pop;
    cmd_t        cmd_head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_limit_reg <= 5'd1;
            timeout_reg     <= 16'd0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_BATCH_LIMIT)
                batch_limit_reg <= cfg_data[4:0];
            else
                timeout_reg <= cfg_data;
        end
    end

    ldb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .sample_key (sample_key),
        .buffer_tag (buffer_tag),
        .slot_index (slot_index),
        .cmd_valid  (cmd_valid),
        .cmd_head   (cmd_head),
        .cmd_pop    (cmd_pop)
    );

    ldb_back #(
        .FILTER_DEPTH (FILTER_DEPTH),
        .MAX_BATCH    (MAX_BATCH),
        .KEY_BITS     (KEY_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_head      (cmd_head),
        .cmd_pop       (cmd_pop),
        .batch_limit   (batch_limit_reg),
        .timeout_ticks (timeout_reg),
        .result_strobe (result_strobe),
        .result_kind   (result_kind),
        .batch_tag     (batch_tag),
        .batch_size    (batch_size),
        .sample_slot   (sample_slot),
        .learned_key   (learned_key),
        .last_of_batch (last_of_batch)
    );

endmodule
